// ----- sv/lfce_pkg.sv -----
// Shared types, codes and width helpers for the lazy-flags condition evaluator.
`timescale 1ns / 1ps
`default_nettype none

package lfce_pkg;

  localparam int unsigned KindW  = 3;
  localparam int unsigned WidthW = 3;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CondW  = 4;

  typedef enum logic [KindW-1:0] {
    KindAdd = 3'd0,
    KindSub = 3'd1,
    KindAnd = 3'd2,
    KindOr  = 3'd3,
    KindXor = 3'd4,
    KindDec = 3'd5
  } op_kind_e;

  localparam logic [WidthW-1:0] Width1B = 3'd1;
  localparam logic [WidthW-1:0] Width2B = 3'd2;
  localparam logic [WidthW-1:0] Width4B = 3'd4;

  localparam logic [CondW-1:0] CondSelMask = 4'hE;
  localparam logic [CondW-1:0] CondInvMask = 4'h1;

  localparam logic [CondW-1:0] SelO  = 4'h0;
  localparam logic [CondW-1:0] SelB  = 4'h2;
  localparam logic [CondW-1:0] SelE  = 4'h4;
  localparam logic [CondW-1:0] SelBe = 4'h6;
  localparam logic [CondW-1:0] SelS  = 4'h8;
  localparam logic [CondW-1:0] SelP  = 4'hA;
  localparam logic [CondW-1:0] SelL  = 4'hC;
  localparam logic [CondW-1:0] SelLe = 4'hE;

  typedef struct packed {
    logic zf;
    logic sf;
    logic cf;
    logic of;
  } flags_t;

  function automatic logic [DataW-1:0] width_mask(input logic [WidthW-1:0] w);
    logic [DataW-1:0] m;
    case (w)
      Width1B: m = 32'h0000_00FF;
      Width2B: m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [DataW-1:0] width_sign(input logic [WidthW-1:0] w);
    logic [DataW-1:0] s;
    case (w)
      Width1B: s = 32'h0000_0080;
      Width2B: s = 32'h0000_8000;
      default: s = 32'h8000_0000;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- sv/lfce_req_if.sv -----
// Request channel: valid/ready handshake with the query fields.
`timescale 1ns / 1ps
`default_nettype none

interface lfce_req_if;
  import lfce_pkg::*;

  logic              valid;
  logic              ready;
  logic [KindW-1:0]  op_kind;
  logic [WidthW-1:0] op_width;
  logic [DataW-1:0]  result_value;
  logic [DataW-1:0]  first_operand;
  logic [DataW-1:0]  second_operand;
  logic [CondW-1:0]  cond_code;

  modport source (
    output valid, op_kind, op_width, result_value, first_operand, second_operand, cond_code,
    input  ready
  );

  modport sink (
    input  valid, op_kind, op_width, result_value, first_operand, second_operand, cond_code,
    output ready
  );

endinterface

`default_nettype wire

// ----- sv/lfce_rsp_if.sv -----
// Response channel: valid/ready handshake with the condition outcome.
`timescale 1ns / 1ps
`default_nettype none

interface lfce_rsp_if;

  logic valid;
  logic ready;
  logic cond_true;
  logic eval_error;

  modport source (
    output valid, cond_true, eval_error,
    input  ready
  );

  modport sink (
    input  valid, cond_true, eval_error,
    output ready
  );

endinterface

`default_nettype wire

// ----- sv/lfce_flags.sv -----
// Flag derivation: ZF, SF, CF and OF of the last operation at its width.
`timescale 1ns / 1ps
`default_nettype none

module lfce_flags (
  input  logic [lfce_pkg::KindW-1:0]  op_kind_i,
  input  logic [lfce_pkg::WidthW-1:0] op_width_i,
  input  logic [lfce_pkg::DataW-1:0]  result_value_i,
  input  logic [lfce_pkg::DataW-1:0]  first_operand_i,
  input  logic [lfce_pkg::DataW-1:0]  second_operand_i,
  output lfce_pkg::flags_t            flags_o
);
  import lfce_pkg::*;

  logic [DataW-1:0] mask;
  logic [DataW-1:0] sign;
  logic [DataW-1:0] a;
  logic [DataW-1:0] b;
  logic [DataW-1:0] r;
  logic [DataW:0]   sum;
  logic [DataW-1:0] sum_t;
  logic [DataW-1:0] diff_t;
  logic             add_cf;
  logic             add_of;
  logic             sub_cf;
  logic             sub_of;

  always_comb begin
    mask   = width_mask(op_width_i);
    sign   = width_sign(op_width_i);
    a      = first_operand_i & mask;
    b      = second_operand_i & mask;
    r      = result_value_i & mask;
    sum    = {1'b0, a} + {1'b0, b};
    sum_t  = sum[DataW-1:0] & mask;
    add_cf = |(sum & ~{1'b0, mask});
    add_of = |(((a ^ sum_t) & (b ^ sum_t)) & sign);
    diff_t = (a - b) & mask;
    sub_cf = a < b;
    sub_of = |(((a ^ b) & (a ^ diff_t)) & sign);

    flags_o.zf = (r == '0);
    flags_o.sf = |(r & sign);
    flags_o.cf = 1'b0;
    flags_o.of = 1'b0;
    case (op_kind_i)
      KindAdd: begin
        flags_o.cf = add_cf;
        flags_o.of = add_of;
      end
      KindSub: begin
        flags_o.cf = sub_cf;
        flags_o.of = sub_of;
      end
      KindDec: begin
        flags_o.of = (a == sign);
      end
      default: begin
        flags_o.cf = 1'b0;
        flags_o.of = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/lfce_cond.sv -----
// Condition select: evaluates the subcode against the flags and flags errors.
`timescale 1ns / 1ps
`default_nettype none

module lfce_cond (
  input  lfce_pkg::flags_t            flags_i,
  input  logic [lfce_pkg::KindW-1:0]  op_kind_i,
  input  logic [lfce_pkg::WidthW-1:0] op_width_i,
  input  logic [lfce_pkg::CondW-1:0]  cond_code_i,
  output logic                        cond_true_o,
  output logic                        eval_error_o
);
  import lfce_pkg::*;

  logic [CondW-1:0] sel;
  logic             width_ok;
  logic             err;
  logic             val;

  always_comb begin
    sel      = cond_code_i & CondSelMask;
    width_ok = (op_width_i == Width1B) || (op_width_i == Width2B) || (op_width_i == Width4B);
    err      = (op_kind_i > KindDec) || !width_ok || (sel == SelP) ||
               ((op_kind_i == KindDec) && ((sel == SelB) || (sel == SelBe)));

    case (sel)
      SelO:    val = flags_i.of;
      SelB:    val = flags_i.cf;
      SelE:    val = flags_i.zf;
      SelBe:   val = flags_i.zf | flags_i.cf;
      SelS:    val = flags_i.sf;
      SelL:    val = flags_i.sf ^ flags_i.of;
      default: val = flags_i.zf | (flags_i.sf ^ flags_i.of);
    endcase
    if ((cond_code_i & CondInvMask) != '0) begin
      val = !val;
    end

    cond_true_o  = !err && val;
    eval_error_o = err;
  end

endmodule

`default_nettype wire

// ----- sv/lazy_flags_condition_eval.sv -----
// Top level: request register, flag and condition logic, response register.
`timescale 1ns / 1ps
`default_nettype none

// Answers one x86 condition query per cycle from a lazily kept flag record
// (operation kind, width, result and operands). A request is captured in an
// input register, the flags and the condition are worked out in one pass of
// combinational logic, and the outcome lands in a response register.
// Requests are taken every cycle while the response side keeps up; a response
// held by the sink still lets one more request into the input register.
// Parity conditions, carry conditions after DEC, unknown kinds and widths
// other than 1, 2 or 4 bytes answer with eval_error set and cond_true clear.
module lazy_flags_condition_eval (
  input  logic       clk_i,
  input  logic       rst_ni,
  lfce_req_if.sink   req_i,
  lfce_rsp_if.source rsp_o
);
  import lfce_pkg::*;

  logic              req_valid_q;
  logic              req_valid_d;
  logic [KindW-1:0]  op_kind_q;
  logic [WidthW-1:0] op_width_q;
  logic [DataW-1:0]  result_value_q;
  logic [DataW-1:0]  first_operand_q;
  logic [DataW-1:0]  second_operand_q;
  logic [CondW-1:0]  cond_code_q;

  logic              rsp_valid_q;
  logic              rsp_valid_d;
  logic              cond_true_q;
  logic              eval_error_q;

  logic              rsp_free;
  logic              req_free;
  logic              req_take;
  flags_t            flags;
  logic              cond_true;
  logic              eval_error;

  assign rsp_free    = !rsp_valid_q || rsp_o.ready;
  assign req_free    = !req_valid_q || rsp_free;
  assign req_i.ready = req_free;
  assign req_take    = req_i.valid && req_free;

  assign req_valid_d = req_free ? req_i.valid : req_valid_q;
  assign rsp_valid_d = rsp_free ? req_valid_q : rsp_valid_q;

  lfce_flags u_flags (
    .op_kind_i        (op_kind_q),
    .op_width_i       (op_width_q),
    .result_value_i   (result_value_q),
    .first_operand_i  (first_operand_q),
    .second_operand_i (second_operand_q),
    .flags_o          (flags)
  );

  lfce_cond u_cond (
    .flags_i      (flags),
    .op_kind_i    (op_kind_q),
    .op_width_i   (op_width_q),
    .cond_code_i  (cond_code_q),
    .cond_true_o  (cond_true),
    .eval_error_o (eval_error)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // capture request
  always_ff @(posedge clk_i) begin
    if (req_take) begin
      op_kind_q        <= req_i.op_kind;
      op_width_q       <= req_i.op_width;
      result_value_q   <= req_i.result_value;
      first_operand_q  <= req_i.first_operand;
      second_operand_q <= req_i.second_operand;
      cond_code_q      <= req_i.cond_code;
    end
  end

  // advance outcome when the response slot frees up
  always_ff @(posedge clk_i) begin
    if (rsp_free && req_valid_q) begin
      cond_true_q  <= cond_true;
      eval_error_q <= eval_error;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.cond_true  = cond_true_q;
  assign rsp_o.eval_error = eval_error_q;

endmodule

`default_nettype wire
